// ----- rtl/tavr_pkg.sv -----
// Shared types and constants for the two-axis velocity ramp.
// Holds register indexes, reset values, key codes and field widths.
// No dependencies.
package tavr_pkg;

    localparam int VelocityWidthDefault = 16;

    localparam int RegWidth      = 15;
    localparam int KeyCodeWidth  = 10;
    localparam int KeyValueWidth = 2;
    localparam int OutFieldWidth = 16;
    localparam int CfgIndexWidth = 3;

    typedef logic [RegWidth-1:0]      reg_val_t;
    typedef logic [KeyCodeWidth-1:0]  key_code_t;
    typedef logic [KeyValueWidth-1:0] key_value_t;
    typedef logic [CfgIndexWidth-1:0] cfg_index_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_MAX_LINEAR         = 3'd0,
        REG_MAX_ANGULAR        = 3'd1,
        REG_LINEAR_ACCEL_STEP  = 3'd2,
        REG_LINEAR_DECEL_STEP  = 3'd3,
        REG_ANGULAR_ACCEL_STEP = 3'd4,
        REG_ANGULAR_DECEL_STEP = 3'd5
    } cfg_reg_t;

    localparam reg_val_t MaxLinearReset        = 15'd3277;
    localparam reg_val_t MaxAngularReset       = 15'd7373;
    localparam reg_val_t LinearAccelStepReset  = 15'd25;
    localparam reg_val_t LinearDecelStepReset  = 15'd33;
    localparam reg_val_t AngularAccelStepReset = 15'd82;
    localparam reg_val_t AngularDecelStepReset = 15'd98;

    localparam key_code_t KeyCodeUp    = 10'd103;
    localparam key_code_t KeyCodeLeft  = 10'd105;
    localparam key_code_t KeyCodeRight = 10'd106;
    localparam key_code_t KeyCodeDown  = 10'd108;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } held_t;

endpackage

// ----- rtl/tavr_keys.sv -----
// Arrow key held flags for the velocity ramp.
// Depends on tavr_pkg for key codes and the held_t struct.
module tavr_keys (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               key_en,
    input  tavr_pkg::key_code_t  key_code,
    input  tavr_pkg::key_value_t key_value,
    output tavr_pkg::held_t    held
);
    import tavr_pkg::*;

    held_t held_reg;
    held_t held_next;
    logic  pressed;

    assign pressed = (key_value != '0);

    always_comb
    begin
        held_next = held_reg;
        if (key_en)
        begin
            unique case (key_code)
                KeyCodeUp:    held_next.up    = pressed;
                KeyCodeDown:  held_next.down  = pressed;
                KeyCodeLeft:  held_next.left  = pressed;
                KeyCodeRight: held_next.right = pressed;
                default:      held_next = held_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    assign held = held_reg;

endmodule

// ----- rtl/tavr_ramp_axis.sv -----
// One axis of the velocity ramp: target select, bounded step, clamp, saturate.
// Pure combinational; depends on tavr_pkg for register widths.
module tavr_ramp_axis #(
    parameter int VELOCITY_WIDTH = tavr_pkg::VelocityWidthDefault
) (
    input  logic signed [VELOCITY_WIDTH-1:0] now,
    input  logic                             pos,
    input  logic                             neg,
    input  tavr_pkg::reg_val_t               limit,
    input  tavr_pkg::reg_val_t               accel,
    input  tavr_pkg::reg_val_t               decel,
    output logic signed [VELOCITY_WIDTH-1:0] next
);
    import tavr_pkg::*;

    // Wide enough for the step sum at any width, and for the 15-bit limits.
    localparam int BaseWidth = (VELOCITY_WIDTH > RegWidth + 1) ? VELOCITY_WIDTH : RegWidth + 1;
    localparam int CW = BaseWidth + 2;

    localparam logic signed [CW-1:0] SatHi =
        {{(CW-VELOCITY_WIDTH+1){1'b0}}, {(VELOCITY_WIDTH-1){1'b1}}};
    localparam logic signed [CW-1:0] SatLo =
        {{(CW-VELOCITY_WIDTH+1){1'b1}}, {(VELOCITY_WIDTH-1){1'b0}}};

    logic signed [CW-1:0] now_x;
    logic signed [CW-1:0] lim_x;
    logic signed [CW-1:0] target;
    logic signed [CW-1:0] step;
    logic signed [CW-1:0] moved;
    logic signed [CW-1:0] clamped;
    logic signed [CW-1:0] sat;

    always_comb
    begin
        now_x  = CW'(now);
        lim_x  = $signed({{(CW-RegWidth){1'b0}}, limit});
        target = '0;
        if (pos)
        begin
            target = target + lim_x;
        end
        if (neg)
        begin
            target = target - lim_x;
        end

        step = (target != '0) ? $signed({{(CW-RegWidth){1'b0}}, accel})
                              : $signed({{(CW-RegWidth){1'b0}}, decel});

        // Move toward the target, never past it.
        moved = now_x;
        if (now_x < target)
        begin
            moved = now_x + step;
            if (moved > target)
            begin
                moved = target;
            end
        end
        else if (now_x > target)
        begin
            moved = now_x - step;
            if (moved < target)
            begin
                moved = target;
            end
        end

        clamped = moved;
        if (clamped > lim_x)
        begin
            clamped = lim_x;
        end
        if (clamped < -lim_x)
        begin
            clamped = -lim_x;
        end

        sat = clamped;
        if (sat > SatHi)
        begin
            sat = SatHi;
        end
        if (sat < SatLo)
        begin
            sat = SatLo;
        end

        next = sat[VELOCITY_WIDTH-1:0];
    end

endmodule

// ----- rtl/two_axis_velocity_ramp.sv -----
// Top level of the two-axis velocity ramp (arrow keys to ramped velocities).
// Depends on tavr_pkg, tavr_keys and tavr_ramp_axis.
//
//   channel  | direction | tdata / data             | tuser      | handshake
//   ---------+-----------+--------------------------+------------+----------------------
//   s_axis   | in        | [9:0] key_code,          | [0]        | s_tvalid / s_tready
//            |           | [11:10] key_value        | req_type   |
//   m_axis   | out       | [15:0] linear_velocity,  | -          | m_tvalid / m_tready
//            |           | [31:16] angular_velocity |            |
//   cfg      | in        | cfg_index, cfg_data      | -          | cfg_valid / cfg_ready
//
// Every input beat waits in the input register, where the ramp logic works
// on it; a beat may enter every cycle unless a held tick is stalled. Key beats
// update the held flags and produce nothing; tick beats update both
// velocities and load the output register as they leave the input register.
// The ramp stage stalls only when a tick meets an output register that is
// full and not being drained. Reset clears flags and velocities to zero and
// loads the register defaults; the config port is always ready.
module two_axis_velocity_ramp #(
    parameter int VELOCITY_WIDTH = tavr_pkg::VelocityWidthDefault
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // [9:0] key_code, [11:10] key_value
    input  logic [0:0]             s_tuser,   // [0] req_type (0 key, 1 tick)
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [15:0] linear_velocity, [31:16] angular_velocity
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  tavr_pkg::cfg_index_t   cfg_index,
    input  tavr_pkg::reg_val_t     cfg_data
);
    import tavr_pkg::*;

    localparam int ExtWidth = (VELOCITY_WIDTH > OutFieldWidth) ? VELOCITY_WIDTH : OutFieldWidth;

    // Configuration registers
    reg_val_t lin_limit_reg;
    reg_val_t ang_limit_reg;
    reg_val_t linear_accel_reg;
    reg_val_t linear_decel_reg;
    reg_val_t angular_accel_reg;
    reg_val_t angular_decel_reg;

    // Input register
    logic       in_valid_reg;
    logic       in_tick_reg;
    key_code_t  in_code_reg;
    key_value_t in_value_reg;

    // Velocity state and output register
    logic signed [VELOCITY_WIDTH-1:0] lin_now_reg;
    logic signed [VELOCITY_WIDTH-1:0] ang_now_reg;
    logic signed [VELOCITY_WIDTH-1:0] lin_next;
    logic signed [VELOCITY_WIDTH-1:0] ang_next;
    logic signed [ExtWidth-1:0]       lin_ext;
    logic signed [ExtWidth-1:0]       ang_ext;
    logic                             out_valid_reg;
    logic [31:0]                      out_data_reg;

    held_t held;
    logic  advance;
    logic  tick_fire;
    logic  key_fire;
    logic  in_fire;

    // Key beats always drain; a tick needs room in the output register.
    assign advance   = in_valid_reg && (!in_tick_reg || !out_valid_reg || m_tready);
    assign tick_fire = advance && in_tick_reg;
    assign key_fire  = advance && !in_tick_reg;
    assign s_tready  = !in_valid_reg || advance;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Register writes; drop indexes past the last register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_limit_reg     <= MaxLinearReset;
            ang_limit_reg     <= MaxAngularReset;
            linear_accel_reg  <= LinearAccelStepReset;
            linear_decel_reg  <= LinearDecelStepReset;
            angular_accel_reg <= AngularAccelStepReset;
            angular_decel_reg <= AngularDecelStepReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_LINEAR:         lin_limit_reg     <= cfg_data;
                REG_MAX_ANGULAR:        ang_limit_reg     <= cfg_data;
                REG_LINEAR_ACCEL_STEP:  linear_accel_reg  <= cfg_data;
                REG_LINEAR_DECEL_STEP:  linear_decel_reg  <= cfg_data;
                REG_ANGULAR_ACCEL_STEP: angular_accel_reg <= cfg_data;
                REG_ANGULAR_DECEL_STEP: angular_decel_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Input register: load a new beat, or empty once the held beat advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_tick_reg  <= s_tuser[0];
            in_code_reg  <= s_tdata[KeyCodeWidth-1:0];
            in_value_reg <= s_tdata[KeyCodeWidth+KeyValueWidth-1:KeyCodeWidth];
        end
    end

    tavr_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_en    (key_fire),
        .key_code  (in_code_reg),
        .key_value (in_value_reg),
        .held      (held)
    );

    tavr_ramp_axis #(
        .VELOCITY_WIDTH (VELOCITY_WIDTH)
    ) u_linear (
        .now   (lin_now_reg),
        .pos   (held.up),
        .neg   (held.down),
        .limit (lin_limit_reg),
        .accel (linear_accel_reg),
        .decel (linear_decel_reg),
        .next  (lin_next)
    );

    tavr_ramp_axis #(
        .VELOCITY_WIDTH (VELOCITY_WIDTH)
    ) u_angular (
        .now   (ang_now_reg),
        .pos   (held.left),
        .neg   (held.right),
        .limit (ang_limit_reg),
        .accel (angular_accel_reg),
        .decel (angular_decel_reg),
        .next  (ang_next)
    );

    // Sign-extend or truncate the stored velocity to the 16-bit output field.
    assign lin_ext = ExtWidth'(lin_next);
    assign ang_ext = ExtWidth'(ang_next);

    // Advance the velocities on a tick and load the result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_now_reg   <= '0;
            ang_now_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            lin_now_reg   <= lin_next;
            ang_now_reg   <= ang_next;
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            out_data_reg <= {ang_ext[OutFieldWidth-1:0], lin_ext[OutFieldWidth-1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sim/two_axis_velocity_ramp_tb.sv -----
// Self-checking testbench for two_axis_velocity_ramp: key and tick beats in, velocity pairs out.
// Holds its own ramp predictor and checks every m_axis beat in order against it.
// Depends on tavr_pkg and the two_axis_velocity_ramp RTL.
module two_axis_velocity_ramp_tb;
    import tavr_pkg::*;

    localparam int CycleLimit    = 200_000;
    localparam int ItemsPerPhase = 200;
    localparam int RandomPhases  = 7;
    localparam int DrainCycles   = 6;

    localparam logic ReqKey  = 1'b0;
    localparam logic ReqTick = 1'b1;

    localparam key_value_t KeyReleased = 2'd0;
    localparam key_value_t KeyPressed  = 2'd1;
    localparam key_value_t KeyRepeat   = 2'd2;
    localparam key_value_t KeyValueTop = 2'd3;
    localparam key_code_t  KeyCodeTop  = 10'd1023;
    localparam reg_val_t   RegTop      = 15'h7FFF;

    // Indexes past the register file; writes there must change nothing.
    localparam cfg_index_t SpareIndexLo = 3'd6;
    localparam cfg_index_t SpareIndexHi = 3'd7;

    typedef struct packed {
        logic       tick;
        key_code_t  code;
        key_value_t value;
    } stim_item_t;

    typedef struct packed {
        logic signed [15:0] linear;
        logic signed [15:0] angular;
    } velocity_pair_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = '0;
    reg_val_t    cfg_data  = '0;

    stim_item_t     pending_items[$];
    velocity_pair_t expected_velocities[$];
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // Predictor copy of the registers and the block state.
    reg_val_t lin_limit          = MaxLinearReset;
    reg_val_t ang_limit          = MaxAngularReset;
    reg_val_t linear_accel_step  = LinearAccelStepReset;
    reg_val_t linear_decel_step  = LinearDecelStepReset;
    reg_val_t angular_accel_step = AngularAccelStepReset;
    reg_val_t angular_decel_step = AngularDecelStepReset;
    held_t    held               = '0;
    logic signed [15:0] linear_now  = '0;
    logic signed [15:0] angular_now = '0;

    two_axis_velocity_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Move one axis toward its key target by one step, then clamp to the limit.
    function automatic logic signed [15:0] ramp_toward_target(
        input logic signed [15:0] now, input logic pos, input logic neg,
        input reg_val_t lim, input reg_val_t accel, input reg_val_t decel);
        int v;
        int limit;
        int target;
        int step_size;
        v = now;
        limit = lim;
        target = 0;
        if (pos)
            target += limit;
        if (neg)
            target -= limit;
        step_size = (target != 0) ? accel : decel;
        if (v < target)
        begin
            v += step_size;
            if (v > target)
                v = target;
        end
        else if (v > target)
        begin
            v -= step_size;
            if (v < target)
                v = target;
        end
        if (v > limit)
            v = limit;
        if (v < -limit)
            v = -limit;
        return v[15:0];
    endfunction

    // Driver: predict on each accepted beat, then offer the next pending item.
    always @(posedge clk)
    begin : drive_input
        stim_item_t next_item;
        logic       pressed;
        if (s_tvalid && s_tready)
        begin
            if (s_tuser[0] == ReqTick)
            begin
                linear_now = ramp_toward_target(linear_now, held.up, held.down, lin_limit,
                                                linear_accel_step, linear_decel_step);
                angular_now = ramp_toward_target(angular_now, held.left, held.right,
                                                 ang_limit, angular_accel_step,
                                                 angular_decel_step);
                expected_velocities.push_back('{linear: linear_now, angular: angular_now});
            end
            else
            begin
                pressed = (s_tdata[11:10] != KeyReleased);
                case (key_code_t'(s_tdata[9:0]))
                    KeyCodeUp:    held.up    = pressed;
                    KeyCodeDown:  held.down  = pressed;
                    KeyCodeLeft:  held.left  = pressed;
                    KeyCodeRight: held.right = pressed;
                    default: ;
                endcase
            end
        end
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, next_item.value, next_item.code};
                s_tuser  <= next_item.tick;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin : check_output
        velocity_pair_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_velocities.size() == 0)
            begin
                $error("unexpected result beat: linear %0d angular %0d",
                       $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
                mismatch_count++;
            end
            else
            begin
                want = expected_velocities.pop_front();
                if (m_tdata[15:0] !== want.linear)
                begin
                    $error("linear_velocity: expected %0d, got %0d",
                           want.linear, $signed(m_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_tdata[31:16] !== want.angular)
                begin
                    $error("angular_velocity: expected %0d, got %0d",
                           want.angular, $signed(m_tdata[31:16]));
                    mismatch_count++;
                end
            end
        end
        m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Call at a rising edge; returns at the edge that accepted the write.
    task automatic write_reg(input cfg_index_t idx, input reg_val_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MAX_LINEAR:         lin_limit          = val;
            REG_MAX_ANGULAR:        ang_limit          = val;
            REG_LINEAR_ACCEL_STEP:  linear_accel_step  = val;
            REG_LINEAR_DECEL_STEP:  linear_decel_step  = val;
            REG_ANGULAR_ACCEL_STEP: angular_accel_step = val;
            REG_ANGULAR_DECEL_STEP: angular_decel_step = val;
            default: ;
        endcase
    endtask

    // Drop the write channel and move off the edge before queuing beats.
    task automatic finish_writes();
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold until the input side is drained and every result has arrived.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_velocities.size() != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic queue_key(input key_code_t code, input key_value_t value);
        pending_items.push_back('{tick: ReqKey, code: code, value: value});
    endtask

    // Tick beats carry random key fields, which the block must ignore.
    task automatic queue_tick();
        pending_items.push_back('{tick: ReqTick, code: key_code_t'($urandom_range(1023)),
                                  value: key_value_t'($urandom_range(3))});
    endtask

    function automatic reg_val_t pick_limit();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 25)
            return RegTop;
        if (r < 75)
            return reg_val_t'($urandom_range(4000, 1));
        return reg_val_t'($urandom);
    endfunction

    function automatic reg_val_t pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return RegTop;
        if (r < 80)
            return reg_val_t'($urandom_range(300, 1));
        return reg_val_t'($urandom);
    endfunction

    // Mostly ticks and arrow events; a few beats with arbitrary key codes.
    task automatic queue_random(input int count);
        int r;
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                queue_tick();
            else if (r < 92)
            begin
                case ($urandom_range(3))
                    0: queue_key(KeyCodeUp, key_value_t'($urandom_range(3)));
                    1: queue_key(KeyCodeDown, key_value_t'($urandom_range(3)));
                    2: queue_key(KeyCodeLeft, key_value_t'($urandom_range(3)));
                    default: queue_key(KeyCodeRight, key_value_t'($urandom_range(3)));
                endcase
            end
            else
                queue_key(key_code_t'($urandom_range(1023)), key_value_t'($urandom_range(3)));
        end
    endtask

    initial
    begin
        // Directed part at reset register values.
        pending_items.push_back('{tick: ReqTick, code: '0, value: KeyReleased});
        queue_key(KeyCodeUp, KeyPressed);
        queue_tick();
        queue_tick();
        queue_key(KeyCodeLeft, KeyRepeat);
        queue_tick();
        // Both keys of each axis held: targets drop to zero.
        queue_key(KeyCodeRight, KeyValueTop);
        queue_key(KeyCodeDown, KeyPressed);
        queue_tick();
        // Codes that are not arrows: ignored, no result.
        queue_key('0, KeyValueTop);
        queue_key(KeyCodeTop, KeyPressed);
        queue_key(KeyCodeUp + 10'd1, KeyPressed);
        queue_key(KeyCodeRight + 10'd1, KeyReleased);
        pending_items.push_back('{tick: ReqTick, code: KeyCodeTop, value: KeyValueTop});
        queue_key(KeyCodeUp, KeyReleased);
        queue_key(KeyCodeRight, KeyReleased);
        queue_tick();
        queue_key(KeyCodeDown, KeyReleased);
        queue_key(KeyCodeLeft, KeyReleased);
        queue_tick();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Largest limits and steps: jump to the target in one tick; zero linear decel step.
        write_reg(REG_MAX_LINEAR, RegTop);
        write_reg(REG_MAX_ANGULAR, RegTop);
        write_reg(REG_LINEAR_ACCEL_STEP, RegTop);
        write_reg(REG_LINEAR_DECEL_STEP, '0);
        write_reg(REG_ANGULAR_ACCEL_STEP, RegTop);
        write_reg(REG_ANGULAR_DECEL_STEP, RegTop);
        finish_writes();
        queue_key(KeyCodeUp, KeyPressed);
        queue_key(KeyCodeLeft, KeyPressed);
        queue_tick();
        queue_tick();
        wait_idle();

        // Lower the limits under full speed: step first, then clamp; zero max with a key held.
        write_reg(REG_MAX_LINEAR, 15'd100);
        write_reg(REG_MAX_ANGULAR, '0);
        write_reg(REG_LINEAR_ACCEL_STEP, 15'd5);
        finish_writes();
        queue_tick();
        queue_key(KeyCodeUp, KeyReleased);
        queue_key(KeyCodeLeft, KeyReleased);
        queue_tick();
        wait_idle();

        // Random phases; every boundary pauses the sender until all results are in.
        for (int p = 0; p < RandomPhases; p++)
        begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            write_reg(REG_MAX_LINEAR, pick_limit());
            write_reg(REG_MAX_ANGULAR, pick_limit());
            write_reg(REG_LINEAR_ACCEL_STEP, pick_step());
            write_reg(REG_LINEAR_DECEL_STEP, pick_step());
            write_reg(REG_ANGULAR_ACCEL_STEP, pick_step());
            write_reg(REG_ANGULAR_DECEL_STEP, pick_step());
            write_reg((p % 2) ? SpareIndexHi : SpareIndexLo, reg_val_t'($urandom));
            finish_writes();
            queue_random(ItemsPerPhase);
            wait_idle();
        end

        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
